// ===== hdl/spfsf_pkg.sv =====
package spfsf_pkg;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] ST_B0   = 4'd1;
	localparam logic [STEP_W-1:0] ST_B1   = 4'd2;
	localparam logic [STEP_W-1:0] ST_B2   = 4'd3;
	localparam logic [STEP_W-1:0] ST_B3   = 4'd4;
	localparam logic [STEP_W-1:0] ST_B4   = 4'd5;
	localparam logic [STEP_W-1:0] ST_B5   = 4'd6;
	localparam logic [STEP_W-1:0] ST_B6   = 4'd7;
	localparam logic [STEP_W-1:0] ST_B7   = 4'd8;
	localparam logic [STEP_W-1:0] ST_B8   = 4'd9;
	localparam logic [STEP_W-1:0] ST_Q0   = 4'd10;
	localparam logic [STEP_W-1:0] ST_Q1   = 4'd11;
	localparam logic [STEP_W-1:0] ST_Q2   = 4'd12;
	localparam logic [STEP_W-1:0] ST_ERR  = 4'd13;
	localparam logic [STEP_W-1:0] ST_ONE  = 4'd14;

	localparam logic [2:0] M_NONE = 3'd0;
	localparam logic [2:0] M_INIT = 3'd1;
	localparam logic [2:0] M_RD_I = 3'd2;
	localparam logic [2:0] M_RD_J = 3'd3;
	localparam logic [2:0] M_MARK = 3'd4;
	localparam logic [2:0] M_RD_X = 3'd5;

	localparam logic [2:0] DP_NOP    = 3'd0;
	localparam logic [2:0] DP_INIT   = 3'd1;
	localparam logic [2:0] DP_J_INC  = 3'd2;
	localparam logic [2:0] DP_J_SQ   = 3'd3;
	localparam logic [2:0] DP_J_STEP = 3'd4;
	localparam logic [2:0] DP_I_NEXT = 3'd5;
	localparam logic [2:0] DP_X_COF  = 3'd6;
	localparam logic [2:0] DP_BUILT  = 3'd7;

	localparam logic [2:0] O_NONE = 3'd0;
	localparam logic [2:0] O_DONE = 3'd1;
	localparam logic [2:0] O_FACT = 3'd2;
	localparam logic [2:0] O_ERR  = 3'd3;
	localparam logic [2:0] O_ONE  = 3'd4;

	localparam logic [2:0] C_NEXT      = 3'd0;
	localparam logic [2:0] C_ALWAYS    = 3'd1;
	localparam logic [2:0] C_J_MORE    = 3'd2;
	localparam logic [2:0] C_SQ_OUT    = 3'd3;
	localparam logic [2:0] C_NOT_PRIME = 3'd4;
	localparam logic [2:0] C_J_IN      = 3'd5;
	localparam logic [2:0] C_SQ_IN     = 3'd6;
	localparam logic [2:0] C_COF_MORE  = 3'd7;

	typedef struct packed {
		logic [2:0]        mem_op;
		logic [2:0]        dp_op;
		logic [2:0]        out_op;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic j_more;
		logic sq_out;
		logic not_prime;
		logic j_in;
		logic sq_in;
		logic cof_more;
	} status_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
		ucode_t w;
		begin
			w = '{M_NONE, DP_NOP, O_NONE, C_NEXT, ST_IDLE};
			unique case (addr)
				ST_IDLE: w = '{M_NONE, DP_NOP,    O_NONE, C_NEXT,      ST_IDLE};
				ST_B0:   w = '{M_NONE, DP_INIT,   O_NONE, C_NEXT,      ST_IDLE};
				ST_B1:   w = '{M_INIT, DP_J_INC,  O_NONE, C_J_MORE,    ST_B1};
				ST_B2:   w = '{M_NONE, DP_NOP,    O_NONE, C_SQ_OUT,    ST_B8};
				ST_B3:   w = '{M_RD_I, DP_NOP,    O_NONE, C_NEXT,      ST_IDLE};
				ST_B4:   w = '{M_NONE, DP_J_SQ,   O_NONE, C_NOT_PRIME, ST_B7};
				ST_B5:   w = '{M_RD_J, DP_NOP,    O_NONE, C_NEXT,      ST_IDLE};
				ST_B6:   w = '{M_MARK, DP_J_STEP, O_NONE, C_J_IN,      ST_B5};
				ST_B7:   w = '{M_NONE, DP_I_NEXT, O_NONE, C_SQ_IN,     ST_B3};
				ST_B8:   w = '{M_NONE, DP_BUILT,  O_DONE, C_ALWAYS,    ST_IDLE};
				ST_Q0:   w = '{M_RD_X, DP_NOP,    O_NONE, C_NEXT,      ST_IDLE};
				ST_Q1:   w = '{M_NONE, DP_X_COF,  O_FACT, C_COF_MORE,  ST_Q0};
				ST_Q2:   w = '{M_NONE, DP_NOP,    O_NONE, C_ALWAYS,    ST_IDLE};
				ST_ERR:  w = '{M_NONE, DP_NOP,    O_ERR,  C_ALWAYS,    ST_IDLE};
				ST_ONE:  w = '{M_NONE, DP_NOP,    O_ONE,  C_ALWAYS,    ST_IDLE};
				default: w = '{M_NONE, DP_NOP,    O_NONE, C_ALWAYS,    ST_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== hdl/spf_sieve_factorizer_top.sv =====
// Smallest-prime-factor sieve with factorization queries.
// An item is taken when start is high and busy is low; func selects a table
// build (0) or a query of number (1). Results leave on factor, last and error,
// each shown for one cycle with valid high; the receiver cannot stall them.
// A build writes every table entry once and then walks the odd candidates
// below the square root; it reads the entry of each, and for each prime it
// reads and marks its multiples from its square on, all bound by the single
// table port. It gives one result, factor 0 with last set.
// A query stays busy until the last prime factor of number has been given;
// each table read gives a factor and its cofactor, and the cofactor is the
// address of the next read, so the factors follow one another in turn.
// Queries for 0, for 1, for numbers beyond the table or before any build
// read no table entry and give one result.
// Reset clears the sequencer, the output strobe and the built flag; the table
// holds no reset value and is only read after a build has written it.
module spf_sieve_factorizer_top #(
	parameter int TABLE_SIZE = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [15:0] number,
	output logic        valid,
	output logic [15:0] factor,
	output logic        last,
	output logic        error
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam logic [AW:0]   N_J  = (AW + 1)'(TABLE_SIZE);
	localparam logic [AW:0]   N_JL = (AW + 1)'(TABLE_SIZE - 1);
	localparam logic [AW+1:0] N_SQ = (AW + 2)'(TABLE_SIZE);
	localparam logic [20:0]   N_X  = 21'(TABLE_SIZE);

	logic [2*AW-1:0] mem [TABLE_SIZE];
	logic [2*AW-1:0] rd_q;
	logic [AW-1:0]   rd_spf;
	logic [AW-1:0]   rd_cof;

	logic [AW:0]     j_q;
	logic [AW-1:0]   i_q;
	logic [AW-1:0]   k_q;
	logic [AW+1:0]   sq_q;
	logic [AW-1:0]   x_q;
	logic            built_q;

	logic            valid_q;
	logic [15:0]     factor_q;
	logic            last_q;
	logic            error_q;

	spfsf_pkg::ucode_t            uword;
	spfsf_pkg::status_t           status;
	logic [spfsf_pkg::STEP_W-1:0] entry;
	logic                         accept;
	logic [AW:0]                  j_next;
	logic [AW+1:0]                sq_next;
	logic [AW-1:0]                mem_addr;
	logic [2*AW-1:0]              mem_wdata;
	logic                         mem_we;
	logic                         mem_re;

	spfsf_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.entry  (entry),
		.status (status),
		.uword  (uword),
		.busy   (busy)
	);

	assign accept  = start && !busy;
	assign rd_spf  = rd_q[2*AW-1:AW];
	assign rd_cof  = rd_q[AW-1:0];
	assign j_next  = j_q + (AW + 1)'(i_q);
	assign sq_next = sq_q + {i_q, 2'b00} + (AW + 2)'(4);

	always_comb begin
		if (!func) begin
			entry = spfsf_pkg::ST_B0;
		end else if (!built_q || number == 16'd0 || 21'(number) >= N_X) begin
			entry = spfsf_pkg::ST_ERR;
		end else if (number == 16'd1) begin
			entry = spfsf_pkg::ST_ONE;
		end else begin
			entry = spfsf_pkg::ST_Q0;
		end
	end

	assign status.j_more    = (j_q != N_JL);
	assign status.sq_out    = (sq_q >= N_SQ);
	assign status.not_prime = (rd_spf != i_q);
	assign status.j_in      = (j_next < N_J);
	assign status.sq_in     = (sq_next < N_SQ);
	assign status.cof_more  = (rd_cof != AW'(1));

	always_comb begin
		mem_addr  = j_q[AW-1:0];
		mem_wdata = {i_q, k_q};
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (uword.mem_op)
			spfsf_pkg::M_NONE: begin
			end
			spfsf_pkg::M_INIT: begin
				mem_we = 1'b1;
				if (!j_q[0] && j_q >= (AW + 1)'(4)) begin
					mem_wdata = {AW'(2), j_q[AW:1]};
				end else begin
					mem_wdata = {j_q[AW-1:0], AW'(1)};
				end
			end
			spfsf_pkg::M_RD_I: begin
				mem_addr = i_q;
				mem_re   = 1'b1;
			end
			spfsf_pkg::M_RD_J: begin
				mem_re = 1'b1;
			end
			spfsf_pkg::M_MARK: begin
				mem_we = (rd_spf == j_q[AW-1:0]);
			end
			spfsf_pkg::M_RD_X: begin
				mem_addr = x_q;
				mem_re   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= AW'(number);
		end
		case (uword.dp_op)
			spfsf_pkg::DP_INIT: begin
				j_q  <= '0;
				i_q  <= AW'(3);
				sq_q <= (AW + 2)'(9);
			end
			spfsf_pkg::DP_J_INC: begin
				j_q <= j_q + (AW + 1)'(1);
			end
			spfsf_pkg::DP_J_SQ: begin
				j_q <= sq_q[AW:0];
				k_q <= i_q;
			end
			spfsf_pkg::DP_J_STEP: begin
				j_q <= j_next;
				k_q <= k_q + AW'(1);
			end
			spfsf_pkg::DP_I_NEXT: begin
				i_q  <= i_q + AW'(2);
				sq_q <= sq_next;
			end
			spfsf_pkg::DP_X_COF: begin
				x_q <= rd_cof;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (uword.dp_op == spfsf_pkg::DP_BUILT) begin
				built_q <= 1'b1;
			end
			valid_q <= (uword.out_op != spfsf_pkg::O_NONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (uword.out_op)
			spfsf_pkg::O_NONE: begin
			end
			spfsf_pkg::O_DONE: begin
				factor_q <= 16'd0;
				last_q   <= 1'b1;
				error_q  <= 1'b0;
			end
			spfsf_pkg::O_FACT: begin
				factor_q <= 16'(rd_spf);
				last_q   <= !status.cof_more;
				error_q  <= 1'b0;
			end
			spfsf_pkg::O_ERR: begin
				factor_q <= 16'd0;
				last_q   <= 1'b1;
				error_q  <= 1'b1;
			end
			spfsf_pkg::O_ONE: begin
				factor_q <= 16'd1;
				last_q   <= 1'b1;
				error_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign valid  = valid_q;
	assign factor = factor_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

// ===== hdl/spfsf_useq.sv =====
module spfsf_useq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [spfsf_pkg::STEP_W-1:0] entry,
	input  spfsf_pkg::status_t           status,
	output spfsf_pkg::ucode_t            uword,
	output logic                         busy
);

	logic [spfsf_pkg::STEP_W-1:0] step_q;
	logic                         take;

	assign uword = spfsf_pkg::ucode_rom(step_q);
	assign busy  = (step_q != spfsf_pkg::ST_IDLE);

	always_comb begin
		unique case (uword.cond)
			spfsf_pkg::C_NEXT:      take = 1'b0;
			spfsf_pkg::C_ALWAYS:    take = 1'b1;
			spfsf_pkg::C_J_MORE:    take = status.j_more;
			spfsf_pkg::C_SQ_OUT:    take = status.sq_out;
			spfsf_pkg::C_NOT_PRIME: take = status.not_prime;
			spfsf_pkg::C_J_IN:      take = status.j_in;
			spfsf_pkg::C_SQ_IN:     take = status.sq_in;
			spfsf_pkg::C_COF_MORE:  take = status.cof_more;
			default:                take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= spfsf_pkg::ST_IDLE;
		end else if (step_q == spfsf_pkg::ST_IDLE) begin
			if (start) begin
				step_q <= entry;
			end
		end else if (take) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + spfsf_pkg::STEP_W'(1);
		end
	end

endmodule

// ===== hdl/spfsf_chk.sv =====
module spfsf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        valid,
	input logic [15:0] factor,
	input logic        last,
	input logic        error
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("Taken item did not raise busy.");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !valid)
		else $error("Result shown right after an item was taken.");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("Block went idle before the last result of an item.");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && error) |-> (last && factor == 16'd0))
		else $error("Error result is not a single closing result.");

	a_prime_factor: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> (factor >= 16'd2 && !error))
		else $error("Intermediate factor below two.");

endmodule

bind spf_sieve_factorizer_top spfsf_chk u_spfsf_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.factor (factor),
	.last   (last),
	.error  (error)
);
